// ===== hw/rtl/steq_pkg.sv =====
// Package for the sorted timer event queue: sizes, entry and port types,
// result and request codes, and circular index arithmetic. No dependencies.
package steq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 64;
    localparam int DELAY_W     = 32;
    localparam int IN_TAG_W    = 16;
    localparam int OUT_TAG_W   = 16;
    localparam int KIND_W      = 2;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 80;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [TIME_W-1:0]   time_t;
    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [KIND_W-1:0]   kind_t;

    localparam cnt_t FULL_COUNT = cnt_t'(QUEUE_DEPTH);

    localparam kind_t KIND_ACCEPTED = 2'd0;
    localparam kind_t KIND_REJECTED = 2'd1;
    localparam kind_t KIND_EXPIRED  = 2'd2;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_ARM  = 1'b1;

    typedef struct packed {
        time_t due_tick;
        tag_t  tag;
    } entry_t;

    typedef struct packed {
        logic   en;
        idx_t   addr;
        entry_t data;
    } mem_wr_t;

    // Offset from the queue head, wrapped around the circular buffer.
    function automatic idx_t wrap_add(idx_t head, cnt_t off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + (IDX_W + 1)'(off);
        if (sum >= (IDX_W + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/steq_mem.sv =====
// Entry storage for the sorted timer event queue: one write port and one
// registered read port. Depends on steq_pkg.
module steq_mem (
    input  logic             clk,
    input  steq_pkg::mem_wr_t wr,
    input  steq_pkg::idx_t   rd_addr,
    output steq_pkg::entry_t rd_data
);
    import steq_pkg::*;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sorted_timer_event_queue_unit.sv =====
// Sorted timer event queue: tick counter, insertion-sorted circular queue
// walked by a small sequencer. Depends on steq_pkg and steq_mem.
//
//  channel  | dir | tdata (low bit up)              | tuser        | tlast
//  s_axis   | in  | delay_ticks[31:0], event_tag    | req_type     | -
//  m_axis   | out | fired_tag[15:0], due_tick[63:0] | result_kind  | last_of_run
//
// Arm: each entry moved is read, then compared and written, ahead of the
// output transaction. Tick: each entry examined is read, then compared,
// plus one output transaction per expired event. The single memory read
// port and its registered read set this read-then-compare order.
// s_axis_tready is high only when idle; a stalled output holds the
// sequencer. Reset clears the counter and the queue at once; no clearing pass.
module sorted_timer_event_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // delay_ticks[31:0], event_tag[47:32]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // fired_tag[15:0], due_tick[79:16]
    output logic [1:0]  m_axis_tuser,   // result_kind
    output logic        m_axis_tlast
);
    import steq_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_ARM_RD   = 6'b000010,
        ST_ARM_CMP  = 6'b000100,
        ST_TICK_RD  = 6'b001000,
        ST_TICK_CMP = 6'b010000,
        ST_SEND     = 6'b100000
    } state_t;

    state_t  state_reg, state_next;
    state_t  ret_reg, ret_next;
    time_t   now_reg, now_next;
    cnt_t    count_reg, count_next;
    idx_t    head_reg, head_next;
    logic    pend_valid_reg, pend_valid_next;

    cnt_t    idx_reg, idx_next;
    time_t   when_reg, when_next;
    tag_t    tag_reg, tag_next;
    entry_t  pend_reg, pend_next;
    kind_t   out_kind_reg, out_kind_next;
    tag_t    out_tag_reg, out_tag_next;
    time_t   out_time_reg, out_time_next;
    logic    out_last_reg, out_last_next;

    mem_wr_t mem_wr;
    idx_t    rd_addr;
    entry_t  rd_data;

    logic                 in_accept;
    logic [DELAY_W-1:0]   in_delay;
    logic [IN_TAG_W-1:0]  in_tag;

    steq_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_delay      = s_axis_tdata[DELAY_W-1:0];
    assign in_tag        = s_axis_tdata[DELAY_W +: IN_TAG_W];

    assign m_axis_tvalid = (state_reg == ST_SEND);
    assign m_axis_tdata  = {out_time_reg, OUT_TAG_W'(out_tag_reg)};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        pend_valid_next = pend_valid_reg;
        idx_next        = idx_reg;
        when_next       = when_reg;
        tag_next        = tag_reg;
        pend_next       = pend_reg;
        out_kind_next   = out_kind_reg;
        out_tag_next    = out_tag_reg;
        out_time_next   = out_time_reg;
        out_last_next   = out_last_reg;
        mem_wr          = '0;
        rd_addr         = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == REQ_ARM)
                    begin
                        when_next     = now_reg + TIME_W'(in_delay);
                        tag_next      = TAG_BITS'(in_tag);
                        idx_next      = count_reg;
                        out_tag_next  = TAG_BITS'(in_tag);
                        out_time_next = now_reg + TIME_W'(in_delay);
                        out_last_next = 1'b1;
                        ret_next      = ST_IDLE;
                        if (count_reg == FULL_COUNT)
                        begin
                            out_kind_next = KIND_REJECTED;
                            state_next    = ST_SEND;
                        end
                        else
                        begin
                            out_kind_next = KIND_ACCEPTED;
                            state_next    = ST_ARM_RD;
                        end
                    end
                    else
                    begin
                        now_next        = now_reg + TIME_W'(1);
                        pend_valid_next = 1'b0;
                        state_next      = ST_TICK_RD;
                    end
                end
            end
            ST_ARM_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = head_reg;
                    mem_wr.data = '{due_tick: when_reg, tag: tag_reg};
                    count_next  = count_reg + cnt_t'(1);
                    state_next  = ST_SEND;
                end
                else
                begin
                    rd_addr    = wrap_add(head_reg, idx_reg - cnt_t'(1));
                    state_next = ST_ARM_CMP;
                end
            end
            ST_ARM_CMP:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = wrap_add(head_reg, idx_reg);
                if (rd_data.due_tick <= when_reg)
                begin
                    mem_wr.data = '{due_tick: when_reg, tag: tag_reg};
                    count_next  = count_reg + cnt_t'(1);
                    state_next  = ST_SEND;
                end
                else
                begin
                    mem_wr.data = rd_data;
                    idx_next    = idx_reg - cnt_t'(1);
                    state_next  = ST_ARM_RD;
                end
            end
            ST_TICK_RD:
            begin
                rd_addr = head_reg;
                if (count_reg == '0)
                begin
                    if (pend_valid_reg)
                    begin
                        out_kind_next   = KIND_EXPIRED;
                        out_tag_next    = pend_reg.tag;
                        out_time_next   = pend_reg.due_tick;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        ret_next        = ST_IDLE;
                        state_next      = ST_SEND;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_TICK_CMP;
                end
            end
            ST_TICK_CMP:
            begin
                if (rd_data.due_tick <= now_reg)
                begin
                    // pop the due head entry and hold it until its successor is known
                    pend_next       = rd_data;
                    pend_valid_next = 1'b1;
                    head_next       = wrap_add(head_reg, cnt_t'(1));
                    count_next      = count_reg - cnt_t'(1);
                    if (pend_valid_reg)
                    begin
                        out_kind_next = KIND_EXPIRED;
                        out_tag_next  = pend_reg.tag;
                        out_time_next = pend_reg.due_tick;
                        out_last_next = 1'b0;
                        ret_next      = ST_TICK_RD;
                        state_next    = ST_SEND;
                    end
                    else
                    begin
                        state_next = ST_TICK_RD;
                    end
                end
                else if (pend_valid_reg)
                begin
                    out_kind_next   = KIND_EXPIRED;
                    out_tag_next    = pend_reg.tag;
                    out_time_next   = pend_reg.due_tick;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    ret_next        = ST_IDLE;
                    state_next      = ST_SEND;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEND:
            begin
                if (m_axis_tready)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            now_reg        <= '0;
            count_reg      <= '0;
            head_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            now_reg        <= now_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        when_reg     <= when_next;
        tag_reg      <= tag_next;
        pend_reg     <= pend_next;
        out_kind_reg <= out_kind_next;
        out_tag_reg  <= out_tag_next;
        out_time_reg <= out_time_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== sim/sorted_timer_event_queue_unit_tb.sv =====
// Self-checking bench for sorted_timer_event_queue_unit: directed and random arm/tick
// requests, a queue model that predicts every result, and random idling on both streams.
// Depends on steq_pkg and the unit's RTL.
module sorted_timer_event_queue_unit_tb;

    import steq_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 2 * QUEUE_DEPTH + 40;
    localparam int RANDOM_ITEMS  = 170;
    localparam int IDLE_PERCENT  = 28;

    typedef struct packed {
        logic                 req;
        logic [DELAY_W-1:0]   delay;
        logic [IN_TAG_W-1:0]  tag;
    } request_t;

    typedef struct packed {
        kind_t                kind;
        logic [OUT_TAG_W-1:0] tag;
        time_t                when;
        logic                 is_last;
    } timer_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = REQ_TICK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    request_t      pending_requests[$];
    timer_result_t due_results[$];
    request_t      next_req;
    timer_result_t seen;
    timer_result_t wanted;

    time_t         model_now = '0;
    time_t         model_fire[QUEUE_DEPTH] = '{default: '0};
    tag_t          model_tag[QUEUE_DEPTH] = '{default: '0};
    int            model_count = 0;

    int            accepted_count = 0;
    int            cycle_count = 0;
    int            error_count = 0;
    int            arms_taken = 0;
    int            arms_refused = 0;
    int            events_fired = 0;
    int            ticks_sent = 0;
    int            busiest_tick = 0;
    logic          quiet_window;

    assign quiet_window = (accepted_count >= 90) && (accepted_count < 140);

    sorted_timer_event_queue_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic add_arm(input logic [DELAY_W-1:0] delay, input logic [IN_TAG_W-1:0] tag);
        pending_requests.push_back({REQ_ARM, delay, tag});
    endtask

    task automatic add_tick();
        pending_requests.push_back({REQ_TICK, DELAY_W'($urandom), IN_TAG_W'($urandom)});
    endtask

    // Update the queue model with one accepted request and queue its results.
    task automatic apply_request(input request_t r);
        time_t when;
        tag_t  tag;
        int    pos;
        int    due;
        if (r.req == REQ_ARM)
        begin
            when = model_now + time_t'(r.delay);
            tag  = tag_t'(r.tag);
            if (model_count >= QUEUE_DEPTH)
            begin
                due_results.push_back({KIND_REJECTED, OUT_TAG_W'(tag), when, 1'b1});
                arms_refused++;
            end
            else
            begin
                pos = 0;
                while (pos < model_count && model_fire[pos] <= when)
                    pos++;
                for (int i = model_count; i > pos; i--)
                begin
                    model_fire[i] = model_fire[i-1];
                    model_tag[i]  = model_tag[i-1];
                end
                model_fire[pos] = when;
                model_tag[pos]  = tag;
                model_count++;
                due_results.push_back({KIND_ACCEPTED, OUT_TAG_W'(tag), when, 1'b1});
                arms_taken++;
            end
        end
        else
        begin
            model_now = model_now + 1;
            due = 0;
            while (due < model_count && model_fire[due] <= model_now)
                due++;
            for (int i = 0; i < due; i++)
                due_results.push_back({KIND_EXPIRED, OUT_TAG_W'(model_tag[i]),
                                       model_fire[i], (i + 1 == due)});
            for (int i = due; i < model_count; i++)
            begin
                model_fire[i-due] = model_fire[i];
                model_tag[i-due]  = model_tag[i];
            end
            model_count = model_count - due;
            events_fired += due;
            ticks_sent++;
            if (due > busiest_tick)
                busiest_tick = due;
        end
    endtask

    // Driver: present queued requests, idling at random outside the quiet window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= REQ_TICK;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request({s_axis_tuser, s_axis_tdata[DELAY_W-1:0],
                               s_axis_tdata[DELAY_W +: IN_TAG_W]});
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_requests.size() > 0 &&
                    (quiet_window || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    next_req = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {next_req.tag, next_req.delay};
                    s_axis_tuser  <= next_req.req;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and check each result transaction against the model.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = {m_axis_tuser, m_axis_tdata[OUT_TAG_W-1:0],
                        m_axis_tdata[OUT_TAG_W +: TIME_W], m_axis_tlast};
                if (due_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("tb: unexpected result kind=%0d tag=%h fire=%h last=%b",
                                 seen.kind, seen.tag, seen.when, seen.is_last);
                end
                else
                begin
                    wanted = due_results.pop_front();
                    if (seen.kind != wanted.kind || seen.tag != wanted.tag ||
                        seen.when != wanted.when || seen.is_last != wanted.is_last)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("tb: mismatch exp kind=%0d tag=%h fire=%h last=%b",
                                     wanted.kind, wanted.tag, wanted.when, wanted.is_last);
                            $display("tb:          got kind=%0d tag=%h fire=%h last=%b",
                                     seen.kind, seen.tag, seen.when, seen.is_last);
                        end
                    end
                end
            end
            m_axis_tready <= quiet_window || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int burst;

        // Zero delay leaves on the next tick; then a tick with nothing due.
        add_arm(32'd0, 16'h0000);
        add_tick();
        add_tick();
        // Fill with equal fire times, overflow once, then expire all in one tick.
        for (int k = 0; k < QUEUE_DEPTH; k++)
            add_arm(32'd3, 16'h1000 + 16'(k));
        add_arm(32'd5, IN_TAG_W'($urandom));
        add_tick();
        add_tick();
        add_tick();
        add_arm(32'hFFFF_FFFF, 16'hFFFF);

        while (pending_requests.size() < RANDOM_ITEMS)
        begin
            burst = $urandom_range(0, 99);
            if (burst < 60)
            begin
                repeat ($urandom_range(1, 6))
                    add_arm(DELAY_W'($urandom_range(0, 10)), IN_TAG_W'($urandom));
                repeat ($urandom_range(0, 4))
                    add_tick();
            end
            else if (burst < 85)
            begin
                repeat ($urandom_range(1, 8))
                    add_tick();
            end
            else if (burst < 97)
            begin
                add_arm(DELAY_W'($urandom_range(0, 300)), IN_TAG_W'($urandom));
            end
            else
            begin
                add_arm(DELAY_W'($urandom), IN_TAG_W'($urandom));
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d requests: %0d arms taken, %0d refused, %0d ticks",
                 accepted_count, arms_taken, arms_refused, ticks_sent);
        $display("tb: %0d events expired, up to %0d on one tick, %0d mismatches",
                 events_fired, busiest_tick, error_count);
        if (error_count == 0 && due_results.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/steq_pkg.sv
hw/rtl/steq_mem.sv
hw/rtl/sorted_timer_event_queue_unit.sv
sim/sorted_timer_event_queue_unit_tb.sv
